FILE: rtl/bcpc_pkg.sv
// ----------------------------------------------------------------------------
// bcpc_pkg
// Shared constants and elaboration-time functions for the ball color pixel
// classifier: channel statistics, register map and deviation table builder.
// ----------------------------------------------------------------------------
package bcpc_pkg;

    // Register map (word index taken from paddr[2])
    localparam logic REG_IDX_THRESHOLD = 1'b0;

    localparam logic [15:0] THRESHOLD_RESET = 16'd9347;

    // Channel codes for the deviation tables
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Q32 fixed-point constants
    localparam logic [63:0] LO32       = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] ONE_Q32    = 64'h0000_0001_0000_0000;
    localparam logic [63:0] HALF_Q32   = 64'h0000_0000_8000_0000;
    localparam logic [63:0] EINV_Q32   = 64'd1580030169;
    localparam logic [63:0] ISQ2PI_Q32 = 64'd1713444047;

    // Channel mean in 1/16 steps
    function automatic int chan_mu16(input int ch);
        int m;
        unique case (ch)
            CH_RED:   m = 1771;
            CH_GREEN: m = 1187;
            default:  m = 747;
        endcase
        return m;
    endfunction

    // Channel sigma scaled by 1e9
    function automatic logic [63:0] chan_sigma9(input int ch);
        logic [63:0] s;
        unique case (ch)
            CH_RED:   s = 64'd10981340710;
            CH_GREEN: s = 64'd9001518969;
            default:  s = 64'd8541946134;
        endcase
        return s;
    endfunction

    // Q32 product, truncated like the 64-bit arithmetic it mirrors
    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        ah = a >> 32;
        al = a & LO32;
        bh = b >> 32;
        bl = b & LO32;
        return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
    endfunction

    // Unsigned 64-bit quotient and remainder by restoring shift and subtract
    function automatic logic [127:0] udivmod(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = 64'd0;
        r = 65'd0;
        for (int i = 63; i >= 0; i--) begin
            r = {r[63:0], n[i]};
            if (r >= {1'b0, d}) begin
                r    = r - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return {q, r[63:0]};
    endfunction

    // Unsigned 64-bit quotient
    function automatic logic [63:0] udivq(input logic [63:0] n, input logic [63:0] d);
        logic [127:0] qr;
        qr = udivmod(n, d);
        return qr[127:64];
    endfunction

    // floor(n * 2^32 / d), elaboration only
    function automatic logic [63:0] divq(input logic [63:0] n, input logic [63:0] d);
        logic [63:0]  q;
        logic [63:0]  r;
        logic [127:0] qr;
        if (d == 64'd0) begin
            return 64'd0;
        end
        qr = udivmod(n, d);
        q  = qr[127:64];
        r  = qr[63:0];
        for (int i = 0; i < 32; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // exp(-y), y in Q32 below 32
    function automatic logic [63:0] expneg(input logic [63:0] y);
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] t;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] e;
        k   = y >> 32;
        r   = y & LO32;
        t   = ONE_Q32;
        pos = ONE_Q32;
        neg = 64'd0;
        for (int n = 1; n <= 20; n++) begin
            t = udivq(mulq(t, r), 64'(n));
            if ((n & 1) != 0) begin
                neg = neg + t;
            end else begin
                pos = pos + t;
            end
        end
        e = pos - neg;
        for (logic [63:0] n = 64'd0; n < k; n++) begin
            e = mulq(e, EINV_Q32);
        end
        return e;
    endfunction

    // |Phi(x) - 0.5| in Q32, x >= 0 in Q32
    function automatic logic [63:0] deviation(input logic [63:0] x);
        logic [63:0] phi;
        logic [63:0] d;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] f;
        logic [63:0] q;
        if (x >= (64'd8 << 32)) begin
            return HALF_Q32;
        end
        phi = mulq(expneg(mulq(x, x) >> 1), ISQ2PI_Q32);
        if (x < (64'd5 << 31)) begin
            // power series near the mean
            x2 = mulq(x, x);
            t  = x;
            s  = x;
            for (int k = 1; k <= 60; k++) begin
                t = udivq(mulq(t, x2), 64'(2 * k + 1));
                s = s + t;
            end
            d = mulq(phi, s);
            if (d > HALF_Q32) begin
                d = HALF_Q32;
            end
        end else begin
            // Mills-ratio continued fraction in the tail
            f = x;
            for (int k = 80; k >= 1; k--) begin
                f = x + divq(64'(k) << 32, f);
            end
            q = divq(phi, f);
            d = (q >= HALF_Q32) ? 64'd0 : HALF_Q32 - q;
        end
        return d;
    endfunction

    // Deviation of one channel level, Q32
    function automatic logic [63:0] dev_q32(input int ch, input int c);
        int          d16;
        logic [63:0] num;
        logic [63:0] x;
        d16 = 16 * c - chan_mu16(ch);
        num = 64'(d16 < 0 ? -d16 : d16) * 64'd1000000000;
        x   = divq(num, 64'd16 * chan_sigma9(ch));
        return deviation(x);
    endfunction

endpackage

FILE: rtl/bcpc_dev_rom.sv
// ----------------------------------------------------------------------------
// bcpc_dev_rom
// Constant deviation table for one color channel, rounded half up to
// DEVIATION_BITS fractional bits and read combinationally.
// ----------------------------------------------------------------------------
module bcpc_dev_rom
    import bcpc_pkg::*;
#(
    parameter int DEVIATION_BITS = 16,
    parameter int CHANNEL        = 0
) (
    input  logic [7:0]                i_level,
    output logic [DEVIATION_BITS-1:0] o_dev
);

    localparam logic [63:0] RND_ADD = 64'd1 << (31 - DEVIATION_BITS);

    logic [DEVIATION_BITS-1:0] w_rom [256];

    // Build the table entries at elaboration
    for (genvar c = 0; c < 256; c++) begin : g_entry
        localparam logic [63:0] DEV_Q32 = dev_q32(CHANNEL, c);
        localparam logic [63:0] DEV_RND = (DEV_Q32 + RND_ADD) >> (32 - DEVIATION_BITS);
        assign w_rom[c] = DEV_RND[DEVIATION_BITS-1:0];
    end

    // Look up the level
    assign o_dev = w_rom[i_level];

endmodule

FILE: rtl/bcpc_relation.sv
// ----------------------------------------------------------------------------
// bcpc_relation
// Three linear color relation checks; the pixel survives when at most one
// of them fails.
// ----------------------------------------------------------------------------
module bcpc_relation
    import bcpc_pkg::*;
(
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_rel_ok
);

    logic signed [23:0] w_r;
    logic signed [23:0] w_g;
    logic signed [23:0] w_b;
    logic signed [23:0] w_g10k;
    logic signed [23:0] w_r7618;
    logic               w_fail_rg;
    logic               w_fail_rb;
    logic               w_fail_gb;

    assign w_r = signed'({16'd0, i_red});
    assign w_g = signed'({16'd0, i_green});
    assign w_b = signed'({16'd0, i_blue});

    assign w_g10k  = 24'sd10000 * w_g;
    assign w_r7618 = 24'sd7618 * w_r;

    // Red against green band
    assign w_fail_rg = (w_g10k > (w_r7618 - 24'sd26400))
                    || (w_g10k < (w_r7618 - 24'sd176400));

    // Red against blue
    assign w_fail_rb = ((24'sd8 * w_b) > ((24'sd5 * w_r) - 24'sd90))
                    || (w_b < (w_r - 24'sd80));

    // Green against blue
    assign w_fail_gb = ((24'sd7 * w_b) > ((24'sd5 * w_g) + 24'sd40))
                    || ((24'sd4 * w_b) < ((24'sd5 * w_g) - 24'sd255));

    // Reject on two or more failures
    assign o_rel_ok = !((w_fail_rg && w_fail_rb) || (w_fail_rg && w_fail_gb)
                     || (w_fail_rb && w_fail_gb));

endmodule

FILE: rtl/bcpc_cfg.sv
// ----------------------------------------------------------------------------
// bcpc_cfg
// APB-style register port holding the color probability threshold.
// ----------------------------------------------------------------------------
module bcpc_cfg
    import bcpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] o_threshold
);

    logic [15:0] r_threshold;
    logic        w_wr_thr;

    assign pready   = 1'b1;
    assign w_wr_thr = psel && penable && pwrite && (paddr[2] == REG_IDX_THRESHOLD);

    // Write the threshold on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (w_wr_thr) begin
            r_threshold <= pwdata[15:0];
        end
    end

    // Read back
    assign prdata      = (paddr[2] == REG_IDX_THRESHOLD) ? {16'd0, r_threshold} : 32'd0;
    assign o_threshold = r_threshold;

endmodule

FILE: rtl/ball_color_pixel_classifier_unit.sv
// ----------------------------------------------------------------------------
// ball_color_pixel_classifier_unit
// Classifies one RGB pixel per clock as possible ball color or not, while the output is not back-pressured.
// ----------------------------------------------------------------------------
// A result is valid once its pixel has passed through all the register stages.
// Throughput: one pixel per cycle while no stage stalls; the split 3*DEVIATION_BITS-bit product
// pipeline sets the six register stages.
// Stalls: each stage holds its transaction while the next one is full and cannot advance.
// Reset: clears all stage valid bits and sets the threshold to 9347.
module ball_color_pixel_classifier_unit
    import bcpc_pkg::*;
#(
    parameter int DEVIATION_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_red_level,
    input  logic [7:0]  i_green_level,
    input  logic [7:0]  i_blue_level,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_is_ball_color,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DB    = DEVIATION_BITS;
    localparam int PW    = 3 * DB;
    localparam int SHIFT = 3 * DB - 19;

    // Stage valid bits and advance enables
    logic [5:0] r_valid;
    logic [5:0] n_valid;
    logic [5:0] w_adv;

    logic [15:0] w_threshold;

    // Stage 1: registered pixel
    logic [7:0] r_s1_red;
    logic [7:0] r_s1_green;
    logic [7:0] r_s1_blue;

    // Stage 2: deviations and relation result
    logic [DB-1:0] w_dev_r;
    logic [DB-1:0] w_dev_g;
    logic [DB-1:0] w_dev_b;
    logic          w_rel_ok;
    logic [DB-1:0] r_s2_dev_r;
    logic [DB-1:0] r_s2_dev_g;
    logic [DB-1:0] r_s2_dev_b;
    logic          r_s2_rel;

    // Stage 3: red-green product
    logic [2*DB-1:0] r_s3_p2;
    logic [DB-1:0]   r_s3_dev_b;
    logic            r_s3_rel;

    // Stage 4: partial products with blue
    logic [2*DB-1:0] r_s4_pl;
    logic [2*DB-1:0] r_s4_ph;
    logic            r_s4_rel;

    // Stage 5: full product
    logic [PW-1:0] r_s5_prod;
    logic          r_s5_rel;

    // Stage 6: result
    logic          r_s6_pass;
    logic [16:0]   w_kk;
    logic [PW-1:0] w_limit;

    bcpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (w_threshold)
    );

    // Advance a stage when it is empty or its successor advances
    always_comb begin
        w_adv[5] = !r_valid[5] || i_out_ready;
        for (int k = 4; k >= 0; k--) begin
            w_adv[k] = !r_valid[k] || w_adv[k+1];
        end
    end

    // Load each valid bit from its predecessor when the stage advances
    always_comb begin
        n_valid = r_valid;
        if (w_adv[0]) begin
            n_valid[0] = i_in_valid;
        end
        for (int k = 1; k < 6; k++) begin
            if (w_adv[k]) begin
                n_valid[k] = r_valid[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_valid[5];

    // Stage 1: capture the pixel
    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_s1_red   <= i_red_level;
            r_s1_green <= i_green_level;
            r_s1_blue  <= i_blue_level;
        end
    end

    bcpc_dev_rom #(
        .DEVIATION_BITS (DB),
        .CHANNEL        (CH_RED)
    ) u_rom_red (
        .i_level (r_s1_red),
        .o_dev   (w_dev_r)
    );

    bcpc_dev_rom #(
        .DEVIATION_BITS (DB),
        .CHANNEL        (CH_GREEN)
    ) u_rom_green (
        .i_level (r_s1_green),
        .o_dev   (w_dev_g)
    );

    bcpc_dev_rom #(
        .DEVIATION_BITS (DB),
        .CHANNEL        (CH_BLUE)
    ) u_rom_blue (
        .i_level (r_s1_blue),
        .o_dev   (w_dev_b)
    );

    bcpc_relation u_relation (
        .i_red    (r_s1_red),
        .i_green  (r_s1_green),
        .i_blue   (r_s1_blue),
        .o_rel_ok (w_rel_ok)
    );

    // Stage 2: latch deviations and relation verdict
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s2_dev_r <= w_dev_r;
            r_s2_dev_g <= w_dev_g;
            r_s2_dev_b <= w_dev_b;
            r_s2_rel   <= w_rel_ok;
        end
    end

    // Stage 3: multiply red by green
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_s3_p2    <= (2*DB)'(r_s2_dev_r) * (2*DB)'(r_s2_dev_g);
            r_s3_dev_b <= r_s2_dev_b;
            r_s3_rel   <= r_s2_rel;
        end
    end

    // Stage 4: multiply each half of the product by blue
    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r_s4_pl  <= (2*DB)'(r_s3_p2[DB-1:0]) * (2*DB)'(r_s3_dev_b);
            r_s4_ph  <= (2*DB)'(r_s3_p2[2*DB-1:DB]) * (2*DB)'(r_s3_dev_b);
            r_s4_rel <= r_s3_rel;
        end
    end

    // Stage 5: combine the partial products
    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r_s5_prod <= (PW'(r_s4_ph) << DB) + PW'(r_s4_pl);
            r_s5_rel  <= r_s4_rel;
        end
    end

    // Probability limit: (65536 - threshold) scaled to the product format
    assign w_kk    = 17'h10000 - {1'b0, w_threshold};
    assign w_limit = PW'(w_kk) << SHIFT;

    // Stage 6: final verdict
    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_s6_pass <= r_s5_rel && (r_s5_prod <= w_limit);
        end
    end

    assign o_is_ball_color = r_s6_pass;

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Streams RGB pixels through the ball color classifier and compares every
// flag with a scoreboard. Expected flags come from deviation tables built
// here at start-up and an exact product and color relation check, or are
// fixed for some directed rows. Directed pixels run first, then phases of
// random pixels at several thresholds. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import bcpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEV_BITS      = 16;
    localparam int PROD_SHIFT    = 3 * DEV_BITS - 19;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 12;
    localparam int LONG_HOLD     = 80;
    localparam int IDLE_LIMIT    = 2000;
    localparam int PHASE_PIXELS  = 75;
    localparam int MAX_REPORTS   = 10;

    localparam logic [2:0]  ADDR_THRESHOLD = {REG_IDX_THRESHOLD, 2'b00};
    localparam logic [2:0]  ADDR_UNMAPPED  = {~REG_IDX_THRESHOLD, 2'b00};
    localparam logic [63:0] MASK32         = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] Q32_ONE        = 64'h0000_0001_0000_0000;
    localparam logic [63:0] Q32_HALF       = 64'h0000_0000_8000_0000;
    localparam logic [63:0] Q32_INV_E      = 64'd1580030169;
    localparam logic [63:0] Q32_INV_SQRT2PI = 64'd1713444047;

    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_REJECT,
        CHK_ACCEPT
    } t_check;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        t_check     chk;
    } t_pixel_row;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       flag;
    } t_verdict;

    logic        i_clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  red_lvl   = 8'd0;
    logic [7:0]  green_lvl = 8'd0;
    logic [7:0]  blue_lvl  = 8'd0;
    logic        out_ready = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = 3'd0;
    logic [31:0] pwdata    = 32'd0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_is_ball_color;
    logic [31:0] prdata;
    logic        pready;

    logic [DEV_BITS-1:0] dev_table [3][256];
    logic [15:0]         thr_shadow;
    t_verdict            pending_verdicts [$];
    t_pixel_row          directed_rows [22];
    int                  mismatch_count = 0;
    int                  stuck_cycles   = 0;
    int                  send_calm      = 0;
    int                  recv_calm      = 0;
    int                  hold_off_reqs  = 0;

    ball_color_pixel_classifier_unit #(
        .DEVIATION_BITS(DEV_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_red_level    (red_lvl),
        .i_green_level  (green_lvl),
        .i_blue_level   (blue_lvl),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_is_ball_color(o_is_ball_color),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Fixed-point helpers for the deviation tables (Q32, 64-bit wrap)
    // ------------------------------------------------------------------
    function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        ah = a >> 32;
        al = a & MASK32;
        bh = b >> 32;
        bl = b & MASK32;
        return ((ah * bh) << 32) + ah * bl + al * bh + ((al * bl) >> 32);
    endfunction

    function automatic logic [63:0] q32_div(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        int          i;
        if (d == 64'd0) begin
            return 64'd0;
        end
        q = n / d;
        r = n % d;
        for (i = 0; i < 32; i++) begin
            q = q << 1;
            r = r << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return q;
    endfunction

    // exp(-y) for y in Q32 below 32: series on the fraction, 1/e per integer
    function automatic logic [63:0] q32_exp_neg(input logic [63:0] y);
        logic [63:0]     whole;
        logic [63:0]     frac;
        logic [63:0]     term;
        logic [63:0]     sum_even;
        logic [63:0]     sum_odd;
        logic [63:0]     e;
        int              n;
        longint unsigned j;
        whole    = y >> 32;
        frac     = y & MASK32;
        term     = Q32_ONE;
        sum_even = Q32_ONE;
        sum_odd  = 64'd0;
        for (n = 1; n <= 20; n++) begin
            term = q32_mul(term, frac) / 64'(n);
            if ((n % 2) != 0) begin
                sum_odd = sum_odd + term;
            end else begin
                sum_even = sum_even + term;
            end
        end
        e = sum_even - sum_odd;
        for (j = 0; j < whole; j++) begin
            e = q32_mul(e, Q32_INV_E);
        end
        return e;
    endfunction

    // |Phi(x) - 0.5| for x >= 0, all Q32
    function automatic logic [63:0] q32_normal_dev(input logic [63:0] x);
        logic [63:0] pdf;
        logic [63:0] dev;
        logic [63:0] x_sq;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] cf;
        logic [63:0] tail;
        int          k;
        if (x >= (64'd8 << 32)) begin
            return Q32_HALF;
        end
        pdf = q32_mul(q32_exp_neg(q32_mul(x, x) >> 1), Q32_INV_SQRT2PI);
        if (x < (64'd5 << 31)) begin
            // odd power series near the mean
            x_sq = q32_mul(x, x);
            term = x;
            acc  = x;
            for (k = 1; k <= 60; k++) begin
                term = q32_mul(term, x_sq) / 64'(2 * k + 1);
                acc  = acc + term;
            end
            dev = q32_mul(pdf, acc);
            if (dev > Q32_HALF) begin
                dev = Q32_HALF;
            end
        end else begin
            // Mills ratio continued fraction in the tail
            cf = x;
            for (k = 80; k >= 1; k--) begin
                cf = x + q32_div(64'(k) << 32, cf);
            end
            tail = q32_div(pdf, cf);
            dev  = (tail >= Q32_HALF) ? 64'd0 : Q32_HALF - tail;
        end
        return dev;
    endfunction

    function automatic int chan_mean16(input int ch);
        int m;
        case (ch)
            CH_RED:   m = 1771;
            CH_GREEN: m = 1187;
            default:  m = 747;
        endcase
        return m;
    endfunction

    function automatic logic [63:0] chan_sigma_e9(input int ch);
        logic [63:0] s;
        case (ch)
            CH_RED:   s = 64'd10981340710;
            CH_GREEN: s = 64'd9001518969;
            default:  s = 64'd8541946134;
        endcase
        return s;
    endfunction

    // Fill the per-channel deviation tables, rounded half up
    task automatic build_dev_tables();
        int          ch;
        int          c;
        int          d16;
        logic [63:0] num;
        logic [63:0] x;
        logic [63:0] dev;
        for (ch = 0; ch < 3; ch++) begin
            for (c = 0; c < 256; c++) begin
                d16 = 16 * c - chan_mean16(ch);
                num = 64'(d16 < 0 ? -d16 : d16) * 64'd1000000000;
                x   = q32_div(num, 64'd16 * chan_sigma_e9(ch));
                dev = q32_normal_dev(x);
                dev_table[ch][c] = DEV_BITS'((dev + (64'd1 << (31 - DEV_BITS)))
                                             >> (32 - DEV_BITS));
            end
        end
    endtask

    // Probability product test, then two-of-three relation test
    function automatic logic predict_ball_color(input logic [7:0] r, input logic [7:0] g,
                                                input logic [7:0] b, input logic [15:0] thr);
        logic [79:0] prod;
        logic [79:0] lim;
        int          rr;
        int          gg;
        int          bb;
        int          fails;
        prod = 80'(dev_table[CH_RED][r]) * 80'(dev_table[CH_GREEN][g])
               * 80'(dev_table[CH_BLUE][b]);
        lim  = (80'd65536 - 80'(thr)) << PROD_SHIFT;
        if (prod > lim) begin
            return 1'b0;
        end
        rr    = int'(r);
        gg    = int'(g);
        bb    = int'(b);
        fails = 0;
        if (10000 * gg > 7618 * rr - 26400 || 10000 * gg < 7618 * rr - 176400) begin
            fails++;
        end
        if (8 * bb > 5 * rr - 90 || bb < rr - 80) begin
            fails++;
        end
        if (7 * bb > 5 * gg + 40 || 4 * bb < 5 * gg - 255) begin
            fails++;
        end
        return (fails >= 2) ? 1'b0 : 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch @%0t: %s", $realtime, what);
        end
    endtask

    // Draw an idle count; now and then start a stretch with no idling
    task automatic draw_wait(inout int calm, output int n);
        if (calm > 0) begin
            calm--;
            n = 0;
        end else begin
            n = $urandom_range(0, 13);
            if ($urandom_range(0, 19) == 0) begin
                calm = $urandom_range(10, 40);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Register port
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (addr[2] == REG_IDX_THRESHOLD) begin
            thr_shadow = data[15:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [15:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[15:0] !== want) begin
            report_mismatch($sformatf("threshold readback exp %0d got %0d", want,
                                      prdata[15:0]));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Pixel source
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                              input t_check chk);
        int       gap;
        t_verdict v;
        draw_wait(send_calm, gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        red_lvl   <= r;
        green_lvl <= g;
        blue_lvl  <= b;
        in_valid  <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        // Record the verdict of the accepted transaction
        v.red   = r;
        v.green = g;
        v.blue  = b;
        case (chk)
            CHK_REJECT: v.flag = 1'b0;
            CHK_ACCEPT: v.flag = 1'b1;
            default:    v.flag = predict_ball_color(r, g, b, thr_shadow);
        endcase
        pending_verdicts = {pending_verdicts, v};
    endtask

    // Drop valid and hold until every verdict has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly pixels near the ball color and its relation borders, some noise
    task automatic send_random_pixel();
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        int         b_lo;
        int         b_hi;
        if ($urandom_range(0, 9) < 6) begin
            r    = 8'($urandom_range(95, 128));
            g    = 8'((int'(r) * 7618) / 10000 - $urandom_range(0, 20));
            b_lo = int'(r) - 83;
            b_hi = (5 * int'(r) - 90) / 8 + 3;
            b    = 8'($urandom_range(b_lo, b_hi));
        end else begin
            r = 8'($urandom_range(0, 255));
            g = 8'($urandom_range(0, 255));
            b = 8'($urandom_range(0, 255));
        end
        send_pixel(r, g, b, CHK_PREDICT);
    endtask

    task automatic run_phase(input logic [15:0] thr, input bit long_hold, input bit mid_pause);
        int i;
        wait_for_drain();
        apb_write(ADDR_THRESHOLD, {16'($urandom), thr});
        apb_read_check(ADDR_THRESHOLD, thr_shadow);
        if (long_hold) begin
            // Stall the sink while the source keeps offering back to back
            hold_off_reqs++;
            send_calm = 40;
        end
        for (i = 0; i < PHASE_PIXELS; i++) begin
            if (mid_pause && i == PHASE_PIXELS / 2) begin
                wait_for_drain();
            end
            send_random_pixel();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int i;
        directed_rows = '{
            '{8'd0,   8'd0,   8'd0,   CHK_REJECT},
            '{8'd255, 8'd255, 8'd255, CHK_REJECT},
            '{8'd111, 8'd74,  8'd47,  CHK_ACCEPT},
            '{8'd255, 8'd0,   8'd0,   CHK_PREDICT},
            '{8'd0,   8'd255, 8'd0,   CHK_PREDICT},
            '{8'd0,   8'd0,   8'd255, CHK_PREDICT},
            '{8'd255, 8'd255, 8'd0,   CHK_PREDICT},
            '{8'd0,   8'd255, 8'd255, CHK_PREDICT},
            '{8'd255, 8'd0,   8'd255, CHK_PREDICT},
            '{8'd170, 8'd85,  8'd170, CHK_PREDICT},
            '{8'd85,  8'd170, 8'd85,  CHK_PREDICT},
            '{8'd1,   8'd2,   8'd4,   CHK_PREDICT},
            '{8'd128, 8'd64,  8'd32,  CHK_PREDICT},
            '{8'd254, 8'd253, 8'd251, CHK_PREDICT},
            '{8'd111, 8'd90,  8'd47,  CHK_PREDICT},
            '{8'd111, 8'd74,  8'd20,  CHK_PREDICT},
            '{8'd111, 8'd74,  8'd70,  CHK_PREDICT},
            '{8'd125, 8'd85,  8'd52,  CHK_PREDICT},
            '{8'd100, 8'd65,  8'd40,  CHK_PREDICT},
            '{8'd111, 8'd60,  8'd47,  CHK_PREDICT},
            '{8'd130, 8'd74,  8'd47,  CHK_PREDICT},
            '{8'd111, 8'd74,  8'd47,  CHK_PREDICT}
        };
        build_dev_tables();
        thr_shadow = THRESHOLD_RESET;

        // Hold reset, then release at an edge
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset value of the threshold, then the directed table
        apb_read_check(ADDR_THRESHOLD, THRESHOLD_RESET);
        for (i = 0; i < $size(directed_rows); i++) begin
            send_pixel(directed_rows[i].red, directed_rows[i].green, directed_rows[i].blue,
                       directed_rows[i].chk);
        end

        // Unmapped register write must leave the threshold alone
        wait_for_drain();
        apb_write(ADDR_UNMAPPED, $urandom);
        apb_read_check(ADDR_THRESHOLD, thr_shadow);

        // Random phases over a spread of thresholds
        run_phase(16'd0, 1'b0, 1'b0);
        run_phase(16'hFFFF, 1'b0, 1'b0);
        run_phase(16'd32768, 1'b1, 1'b0);
        run_phase(16'($urandom), 1'b0, 1'b1);
        run_phase(16'($urandom), 1'b0, 1'b0);
        run_phase(16'd1, 1'b0, 1'b0);

        // Drain and let any stray result show up
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("PASS ball_color_pixel_classifier_unit");
        end else begin
            $display("FAIL ball_color_pixel_classifier_unit");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------
    initial begin : result_sink
        int       n;
        int       hold_off_done;
        t_verdict v;
        hold_off_done = 0;
        while (!rst_n) @(posedge i_clk);
        forever begin
            if (hold_off_reqs != hold_off_done) begin
                hold_off_done = hold_off_reqs;
                n = LONG_HOLD;
            end else begin
                draw_wait(recv_calm, n);
            end
            if (n > 0) begin
                out_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            // Compare the accepted transaction with the oldest verdict
            if (pending_verdicts.size() == 0) begin
                report_mismatch($sformatf("unexpected result flag=%0b", o_is_ball_color));
            end else begin
                v = pending_verdicts.pop_front();
                if (o_is_ball_color !== v.flag) begin
                    report_mismatch($sformatf("rgb=(%0d,%0d,%0d) thr=%0d exp %0b got %0b",
                                              v.red, v.green, v.blue, thr_shadow, v.flag,
                                              o_is_ball_color));
                end
            end
        end
    end

    // Watchdog on cycles with no transaction anywhere
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
            || (psel && penable)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= IDLE_LIMIT) begin
                $display("FAIL ball_color_pixel_classifier_unit");
                $finish;
            end
        end
    end

endmodule

FILE: filelist.f
rtl/bcpc_pkg.sv
rtl/bcpc_dev_rom.sv
rtl/bcpc_relation.sv
rtl/bcpc_cfg.sv
rtl/ball_color_pixel_classifier_unit.sv
tb/tb.sv
